### rtl/mbmf_pkg.sv
// Package for the masked box mean filter: constants, types and state codes.
`timescale 1ns / 1ps
`default_nettype none
package mbmf_pkg;
	localparam int MaxCols    = 4096;
	localparam int MaxRadius  = 7;
	localparam int SampleBits = 32;

	localparam logic [1:0] RegRows   = 2'd0;
	localparam logic [1:0] RegCols   = 2'd1;
	localparam logic [1:0] RegRadius = 2'd2;
	localparam logic [1:0] RegNodata = 2'd3;

	localparam logic ReqPush  = 1'b0;
	localparam logic ReqFlush = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRITE,
		ST_CHECK,
		ST_CENTRE_RD,
		ST_CENTRE_WAIT,
		ST_CENTRE_CHK,
		ST_WALK_RD,
		ST_WALK_ACC,
		ST_DIV_INIT,
		ST_DIV,
		ST_EMIT
	} state_t;
endpackage
`default_nettype wire

### rtl/mbmf_stream_if.sv
// Valid/ready channel interface carrying one word of payload.
`timescale 1ns / 1ps
`default_nettype none
interface mbmf_stream_if #(
	parameter int W = 33
);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/masked_box_mean_filter.sv
// Top level of the masked box mean filter with its line store and shared divider.
//
// Usage: the in channel carries words {req_type, sample} (req_type in the top bit).
// A push (req_type 0) writes the next raster pixel into the line store and then
// produces every output pixel whose window is complete, one at a time. A flush
// (req_type 1) after the last pixel produces one of the remaining output pixels.
// The out channel carries words {last, mean_value}, last in the top bit.
// Each output pixel is computed by a walk over its window, one line store read
// per tap (a read step, then an accumulate step on the registered data), then a
// restoring divide of one quotient bit per cycle over 64 bits. The input is not
// ready while an item is in work. When the receiver stalls, the result word
// waits in the output register while the next result is computed, and the
// sequencer holds at its emit step until the waiting word is taken. Reset sets
// the counters and the control and configuration registers to their reset
// values; the datapath registers and the line store hold no reset value, and the
// line store is never read before written within a raster. A configuration
// write restarts the stream.
`timescale 1ns / 1ps
`default_nettype none
module masked_box_mean_filter #(
	parameter int MAX_COLS    = mbmf_pkg::MaxCols,
	parameter int MAX_RADIUS  = mbmf_pkg::MaxRadius,
	parameter int SAMPLE_BITS = mbmf_pkg::SampleBits
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	mbmf_stream_if.sink      in_ch,
	mbmf_stream_if.source    out_ch,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import mbmf_pkg::*;

	localparam int SPAN  = 2 * MAX_RADIUS + 1;
	localparam int DEPTH = SPAN * MAX_COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW    = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
	localparam int SW    = $clog2(SPAN + 1);

	// Configuration registers.
	logic [15:0] rows_q;
	logic [12:0] cols_q;
	logic [2:0]  rad_q;
	logic [31:0] nodata_q;

	// Effective values, with zero and oversize codes folded.
	logic [16:0] erows;
	logic [16:0] ecols;
	logic [RW-1:0] erad;
	always_comb begin
		erows = (rows_q == 16'd0) ? 17'd1 : {1'b0, rows_q};
		if (cols_q == 13'd0) ecols = 17'd1;
		else if (32'(cols_q) > MAX_COLS) ecols = 17'(MAX_COLS);
		else ecols = {4'd0, cols_q};
		if (32'(rad_q) > MAX_RADIUS) erad = RW'(MAX_RADIUS);
		else erad = RW'(rad_q);
	end
	logic [SW-1:0] span_w;
	assign span_w = SW'({erad, 1'b1});

	// Stream position; rows tracked as row and row modulo span.
	logic [16:0]   in_row_q, out_row_q;
	logic [CW-1:0] in_col_q, out_col_q;
	logic [SW-1:0] in_slot_q, out_slot_q;
	logic          restart;

	state_t state_q, state_d;

	// Captured push position and window walk counters.
	logic [16:0]   ir_q;
	logic [CW-1:0] ic_q;
	logic [16:0]   wy_q, y1_q;
	logic [17:0]   wx_q, x0_q, x1_q;
	logic [SW-1:0] wslot_q;
	logic          pushed_q;
	logic          flush_q;

	// Accumulators and divider.
	logic signed [63:0] sum_q;
	logic [8:0]         cnt_q;
	logic [63:0]        dividend_q;
	logic [8:0]         rem_q;
	logic [6:0]         dcnt_q;
	logic               neg_q;
	logic [31:0]        res_q;
	logic [31:0]        out_mean_q;
	logic               last_q;
	logic               out_valid_q;

	// Line store, one write and one read port, read data registered.
	logic [31:0]   mem [DEPTH];
	logic [31:0]   rd_q;
	logic          mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [31:0]   samp_ext;
	assign samp_ext = 32'(signed'(in_ch.data[SAMPLE_BITS-1:0]));
	logic [31:0] samp_q;
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= samp_q;
		rd_q <= mem[mem_ra];
	end

	function automatic logic [AW-1:0] addr(input logic [SW-1:0] s, input logic [CW-1:0] c);
		logic [31:0] a;
		a = 32'(s) * 32'(MAX_COLS) + 32'(c);
		return AW'(a);
	endfunction

	// The centre address is held through the wait cycle so that the word
	// checked next is the centre sample.
	assign mem_we = (state_q == ST_WRITE);
	assign mem_wa = addr(in_slot_q, in_col_q);
	assign mem_ra = (state_q == ST_CENTRE_RD || state_q == ST_CENTRE_WAIT)
	                ? addr(out_slot_q, out_col_q)
	                : addr(wslot_q, wx_q[CW-1:0]);

	// Readiness of the next pending output after the current push or flush.
	logic ready_more;
	always_comb begin
		ready_more = 1'b0;
		if (out_row_q < erows) begin
			if (flush_q) ready_more = !pushed_q;
			else if (pushed_q) ready_more = 1'b0;
			else if (17'(out_row_q + 17'(erad)) < ir_q) ready_more = 1'b1;
			else if (17'(out_row_q + 17'(erad)) == ir_q)
				ready_more = (18'(out_col_q) + 18'(erad) <= 18'(ic_q))
				          || (17'(ic_q) == 17'(ecols - 17'd1));
		end
	end

	logic div_ge;
	logic [9:0] div_trial;
	assign div_trial = {rem_q, dividend_q[63]};
	assign div_ge = div_trial >= {1'b0, cnt_q};

	logic fin;
	assign fin = (out_row_q == 17'(erows - 17'd1)) && (17'(out_col_q) == 17'(ecols - 17'd1));

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = {last_q, out_mean_q};

	logic in_acc, out_acc, emit_go;
	assign in_acc  = in_ch.valid && in_ch.ready;
	assign out_acc = out_ch.valid && out_ch.ready;
	assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || out_acc);
	assign restart = cfg_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_acc) begin
				if (in_ch.data[32] == ReqPush)
					state_d = (in_row_q >= erows) ? ST_IDLE : ST_WRITE;
				else
					state_d = (in_row_q >= erows && out_row_q < erows) ? ST_CHECK : ST_IDLE;
			end
			ST_WRITE:       state_d = ST_CHECK;
			ST_CHECK:       state_d = ready_more ? ST_CENTRE_RD : ST_IDLE;
			ST_CENTRE_RD:   state_d = ST_CENTRE_WAIT;
			ST_CENTRE_WAIT: state_d = ST_CENTRE_CHK;
			ST_CENTRE_CHK:  state_d = (rd_q == nodata_q) ? ST_EMIT : ST_WALK_RD;
			ST_WALK_RD:     state_d = ST_WALK_ACC;
			ST_WALK_ACC: begin
				if (wx_q == x1_q && wy_q == y1_q) state_d = ST_DIV_INIT;
				else state_d = ST_WALK_RD;
			end
			ST_DIV_INIT:    state_d = (cnt_q == 9'd0) ? ST_EMIT : ST_DIV;
			ST_DIV:         state_d = (dcnt_q == 7'd63) ? ST_EMIT : ST_DIV;
			ST_EMIT: if (!out_valid_q || out_acc) state_d = (fin || flush_q) ? ST_IDLE : ST_CHECK;
			default:        state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 16'd1; cols_q <= 13'd4096; rad_q <= 3'd1; nodata_q <= 32'hFFFF8000;
			in_row_q <= '0; in_col_q <= '0; in_slot_q <= '0;
			out_row_q <= '0; out_col_q <= '0; out_slot_q <= '0;
			out_valid_q <= 1'b0; pushed_q <= 1'b0; flush_q <= 1'b0;
			ir_q <= '0; ic_q <= '0; last_q <= 1'b0; out_mean_q <= '0;
		end else begin
			if (out_acc && (restart || !emit_go)) out_valid_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					RegRows:   rows_q   <= cfg_data[15:0];
					RegCols:   cols_q   <= cfg_data[12:0];
					RegRadius: rad_q    <= cfg_data[2:0];
					RegNodata: nodata_q <= cfg_data;
					default:   ;
				endcase
			end
			if (restart) begin
				in_row_q <= '0; in_col_q <= '0; in_slot_q <= '0;
				out_row_q <= '0; out_col_q <= '0; out_slot_q <= '0;
			end else begin
				if (state_q == ST_IDLE && in_acc) begin
					flush_q  <= (in_ch.data[32] == ReqFlush);
					pushed_q <= 1'b0;
					ir_q     <= in_row_q;
					ic_q     <= in_col_q;
				end
				if (state_q == ST_WRITE) begin
					if (17'(in_col_q) == 17'(ecols - 17'd1)) begin
						in_col_q  <= '0;
						in_row_q  <= in_row_q + 17'd1;
						in_slot_q <= (in_slot_q == span_w - SW'(1)) ? '0 : in_slot_q + SW'(1);
					end else in_col_q <= in_col_q + CW'(1);
				end
				if (emit_go) begin
					out_valid_q <= 1'b1;
					out_mean_q  <= res_q;
					last_q      <= fin;
					pushed_q    <= flush_q;
					if (fin) begin
						in_row_q <= '0; in_col_q <= '0; in_slot_q <= '0;
						out_row_q <= '0; out_col_q <= '0; out_slot_q <= '0;
					end else if (17'(out_col_q) == 17'(ecols - 17'd1)) begin
						out_col_q  <= '0;
						out_row_q  <= out_row_q + 17'd1;
						out_slot_q <= (out_slot_q == span_w - SW'(1)) ? '0 : out_slot_q + SW'(1);
					end else out_col_q <= out_col_q + CW'(1);
				end
			end
		end
	end

	// Walk and divide datapath.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) samp_q <= samp_ext;
		unique case (state_q)
			ST_CENTRE_CHK: begin
				res_q <= nodata_q;
				sum_q <= '0;
				cnt_q <= '0;
				wy_q  <= (out_row_q >= 17'(erad)) ? out_row_q - 17'(erad) : 17'd0;
				wslot_q <= (out_row_q >= 17'(erad))
				           ? ((out_slot_q >= SW'(erad)) ? out_slot_q - SW'(erad)
				                                        : out_slot_q + SW'(erad) + SW'(1))
				           : '0;
				y1_q <= (17'(out_row_q + 17'(erad)) < erows) ? 17'(out_row_q + 17'(erad))
				                                               : 17'(erows - 17'd1);
				x0_q <= (18'(out_col_q) >= 18'(erad)) ? 18'(out_col_q) - 18'(erad) : 18'd0;
				wx_q <= (18'(out_col_q) >= 18'(erad)) ? 18'(out_col_q) - 18'(erad) : 18'd0;
				x1_q <= (18'(out_col_q) + 18'(erad) < 18'(ecols)) ? 18'(out_col_q) + 18'(erad)
				                                                     : 18'(ecols - 17'd1);
			end
			ST_WALK_ACC: begin
				if (rd_q != nodata_q) begin
					sum_q <= sum_q + 64'(signed'(rd_q));
					cnt_q <= cnt_q + 9'd1;
				end
				if (wx_q == x1_q) begin
					wx_q    <= x0_q;
					wy_q    <= wy_q + 17'd1;
					wslot_q <= (wslot_q == span_w - SW'(1)) ? '0 : wslot_q + SW'(1);
				end else wx_q <= wx_q + 18'd1;
			end
			ST_DIV_INIT: begin
				neg_q      <= sum_q[63];
				dividend_q <= sum_q[63] ? 64'(-sum_q) : 64'(sum_q);
				rem_q      <= '0;
				dcnt_q     <= '0;
			end
			ST_DIV: begin
				rem_q      <= div_ge ? 9'(div_trial - {1'b0, cnt_q}) : div_trial[8:0];
				dividend_q <= {dividend_q[62:0], div_ge};
				dcnt_q     <= dcnt_q + 7'd1;
				if (dcnt_q == 7'd63)
					res_q <= neg_q ? 32'(-{dividend_q[30:0], div_ge}) : {dividend_q[30:0], div_ge};
			end
			default: ;
		endcase
	end

	// Checks on sequencing.
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ch.ready) else $error("input ready while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |=> out_valid_q) else $error("result dropped");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && dcnt_q != 7'd63) |=> state_q == ST_DIV) else $error("divide cut");
	a_cnt_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> cnt_q != 9'd0) else $error("divide by zero");
endmodule
`default_nettype wire

### test/tb.sv
// Self-checking testbench for the masked box mean filter with a built-in window mean predictor.
`timescale 1ns / 1ps
module tb;
	import mbmf_pkg::*;

	// Cycles the block may still be busy after its last expected word, and the
	// longest stretch with no accepted word before the run is declared hung.
	localparam int Settle    = 700;
	localparam int HangLimit = 20000;
	localparam int Span      = 2 * MaxRadius + 1;

	typedef enum {JOB_WORD, JOB_CFG, JOB_DRAIN} job_kind_t;

	typedef struct {
		job_kind_t   kind;
		logic        req;
		logic [31:0] value;
		logic [1:0]  index;
	} job_t;

	typedef struct {
		logic [31:0] mean;
		logic        last;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = RegRows;
	logic [31:0] cfg_data = '0;

	mbmf_stream_if #(.W(33)) in_ch ();
	mbmf_stream_if #(.W(33)) out_ch ();

	masked_box_mean_filter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	job_t   job_q[$];
	pixel_t mean_q[$];
	int     errors = 0;
	int     idle_cycles = 0;
	int     word_total = 0;
	int unsigned issued_words = 0;
	int unsigned accepted_words = 0;

	// Predictor state: a copy of the registers at the widths the block uses, plus
	// the stream counters and the line store.
	logic [15:0] p_rows;
	logic [12:0] p_cols;
	logic [2:0]  p_radius;
	logic [31:0] p_nodata;
	int unsigned in_row, in_col, out_row, out_col;
	logic [31:0] store [0:Span*MaxCols-1];

	function automatic int unsigned rows_eff();
		return (p_rows == 0) ? 1 : p_rows;
	endfunction

	function automatic int unsigned cols_eff();
		if (p_cols == 0) return 1;
		return (p_cols > MaxCols) ? MaxCols : p_cols;
	endfunction

	function automatic int unsigned store_slot(int unsigned row, int unsigned col);
		return (row % (2 * p_radius + 1)) * MaxCols + col;
	endfunction

	// Mean of the valid samples round (r, c); an invalid centre, or a window with
	// no valid sample at all, gives the nodata value back.
	function automatic logic [31:0] window_avg(int unsigned r, int unsigned c);
		int unsigned r0, r1, c0, c1;
		longint sum;
		longint cnt;
		logic [31:0] v;
		sum = 0;
		cnt = 0;
		if (store[store_slot(r, c)] == p_nodata) return p_nodata;
		r0 = (r >= p_radius) ? r - p_radius : 0;
		c0 = (c >= p_radius) ? c - p_radius : 0;
		r1 = (r + p_radius < rows_eff()) ? r + p_radius : rows_eff() - 1;
		c1 = (c + p_radius < cols_eff()) ? c + p_radius : cols_eff() - 1;
		for (int unsigned y = r0; y <= r1; y++) begin
			for (int unsigned x = c0; x <= c1; x++) begin
				v = store[store_slot(y, x)];
				if (v != p_nodata) begin
					sum += longint'(signed'(v));
					cnt++;
				end
			end
		end
		if (cnt == 0) return p_nodata;
		return 32'(sum / cnt);
	endfunction

	// Queues the next output pixel and advances the output counters; the final
	// pixel of the raster returns every counter to zero.
	function automatic bit emit_pixel();
		pixel_t px;
		px.mean = window_avg(out_row, out_col);
		px.last = (out_row == rows_eff() - 1) && (out_col == cols_eff() - 1);
		mean_q.push_back(px);
		if (px.last) begin
			in_row = 0; in_col = 0; out_row = 0; out_col = 0;
		end else begin
			out_col++;
			if (out_col >= cols_eff()) begin
				out_col = 0;
				out_row++;
			end
		end
		return px.last;
	endfunction

	function automatic void predict_word(logic req, logic [31:0] sample);
		int unsigned ir, ic, n;
		ir = in_row;
		ic = in_col;
		n = 0;
		if (req == ReqPush) begin
			// A push past the end of the raster is dropped.
			if (in_row >= rows_eff()) return;
			store[store_slot(ir, ic)] = sample;
			in_col++;
			if (in_col >= cols_eff()) begin
				in_col = 0;
				in_row++;
			end
			// Every output whose window is now complete, up to eight, comes out of this push.
			while (n < 8 && out_row < rows_eff() && out_row + p_radius <= ir &&
			       (out_row + p_radius < ir || out_col + p_radius <= ic ||
			        ic == cols_eff() - 1)) begin
				n++;
				if (emit_pixel()) break;
			end
		end else if (in_row >= rows_eff() && out_row < rows_eff()) begin
			void'(emit_pixel());
		end
	endfunction

	function automatic void apply_cfg(logic [1:0] idx, logic [31:0] val);
		case (idx)
			RegRows:   p_rows = val[15:0];
			RegCols:   p_cols = val[12:0];
			RegRadius: p_radius = val[2:0];
			RegNodata: p_nodata = val;
			default: ;
		endcase
		in_row = 0; in_col = 0; out_row = 0; out_col = 0;
	endfunction

	// Monitor: acceptances on both channels, register writes and the hang watchdog.
	always @(posedge clk) begin
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				accepted_words <= accepted_words + 1;
				moved = 1'b1;
				predict_word(in_ch.data[32], in_ch.data[31:0]);
			end
			if (cfg_we) begin
				moved = 1'b1;
				apply_cfg(cfg_index, cfg_data);
			end
			if (out_ch.valid && out_ch.ready) begin
				moved = 1'b1;
				if (mean_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected word mean=%0d last=%0b", $time,
					         $signed(out_ch.data[31:0]), out_ch.data[32]);
				end else begin
					if (out_ch.data[31:0] !== mean_q[0].mean) begin
						errors++;
						$display("%0t: mean_value expected %0d actual %0d", $time,
						         $signed(mean_q[0].mean), $signed(out_ch.data[31:0]));
					end
					if (out_ch.data[32] !== mean_q[0].last) begin
						errors++;
						$display("%0t: last expected %0b actual %0b", $time,
						         mean_q[0].last, out_ch.data[32]);
					end
					void'(mean_q.pop_front());
				end
			end
			idle_cycles <= moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= HangLimit) begin
				$display("%0t: no progress for %0d cycles", $time, HangLimit);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Driver: bursts of words separated by random gaps. Register writes wait
	// until every expected word has come and the block has had time to settle.
	int burst_left = 4;
	int gap_left = 0;
	int quiet = 0;

	always @(negedge clk) begin
		logic nv;
		logic [32:0] nd;
		logic nwe;
		nv = in_ch.valid;
		nd = in_ch.data;
		nwe = 1'b0;
		if (arst_n) begin
			if (nv && accepted_words == issued_words) nv = 1'b0;
			if (!nv) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (job_q.size() > 0) begin
					case (job_q[0].kind)
						JOB_WORD: begin
							nd = {job_q[0].req, job_q[0].value};
							nv = 1'b1;
							issued_words++;
							void'(job_q.pop_front());
							burst_left--;
							if (burst_left <= 0) begin
								burst_left = $urandom_range(1, 12);
								// Some bursts are followed by no gap at all.
								gap_left = ($urandom_range(0, 3) == 0) ? 0 :
								           $urandom_range(1, 9);
							end
						end
						JOB_DRAIN: begin
							if (mean_q.size() == 0) void'(job_q.pop_front());
						end
						JOB_CFG: begin
							if (mean_q.size() != 0) begin
								quiet = 0;
							end else if (quiet < Settle) begin
								quiet++;
							end else begin
								nwe = 1'b1;
								cfg_index <= job_q[0].index;
								cfg_data <= job_q[0].value;
								void'(job_q.pop_front());
								quiet = 0;
							end
						end
					endcase
				end
			end
		end
		in_ch.valid <= nv;
		in_ch.data <= nd;
		cfg_we <= nwe;
	end

	// Receiver: alternates between always ready, random stalls and long stalls.
	int rx_mode = 0;
	int rx_left = 0;

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_left = $urandom_range(20, 200);
		end
		rx_left--;
		case (rx_mode)
			0: out_ch.ready <= 1'b1;
			1: out_ch.ready <= $urandom_range(0, 1);
			default: out_ch.ready <= ($urandom_range(0, 15) == 0);
		endcase
	end

	task automatic add_word(logic req, logic [31:0] val);
		job_t j;
		j.kind = JOB_WORD;
		j.req = req;
		j.value = val;
		j.index = RegRows;
		job_q.push_back(j);
		word_total++;
	endtask

	task automatic add_cfg(logic [1:0] idx, logic [31:0] val);
		job_t j;
		j.kind = JOB_CFG;
		j.req = ReqPush;
		j.value = val;
		j.index = idx;
		job_q.push_back(j);
	endtask

	task automatic add_drain();
		job_t j;
		j.kind = JOB_DRAIN;
		j.req = ReqPush;
		j.value = '0;
		j.index = RegRows;
		job_q.push_back(j);
	endtask

	function automatic logic [31:0] pick_sample(logic [31:0] nodata);
		case ($urandom_range(0, 9))
			0, 1: return nodata;
			2: return 32'h7fffffff;
			3: return 32'h80000000;
			4, 5: return 32'($urandom_range(0, 2000)) - 32'd1000;
			default: return $urandom;
		endcase
	endfunction

	// One raster: all four registers, then `pushes` pixels with stray flushes
	// mixed in, then tail flushes, enough in complete rasters to drain the last rows plus a couple spare.
	task automatic add_raster(int rows, int cols, int rad, logic [31:0] nodata,
	                          int pushes, int tail);
		add_cfg(RegRows, rows);
		add_cfg(RegCols, cols);
		add_cfg(RegRadius, rad);
		add_cfg(RegNodata, nodata);
		for (int i = 0; i < pushes; i++) begin
			if ($urandom_range(0, 9) == 0) add_word(ReqFlush, $urandom);
			add_word(ReqPush, pick_sample(nodata));
		end
		for (int i = 0; i < tail; i++) add_word(ReqFlush, $urandom);
	endtask

	initial begin
		int rows, cols, rad;
		logic [31:0] nd;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		p_rows = 16'd1;
		p_cols = 13'd4096;
		p_radius = 3'd1;
		p_nodata = 32'hffff8000;
		in_row = 0; in_col = 0; out_row = 0; out_col = 0;
		foreach (store[i]) store[i] = '0;

		// Directed: zero rows and columns act as one, with an invalid single pixel.
		add_cfg(RegRows, 0);
		add_cfg(RegCols, 0);
		add_cfg(RegRadius, 0);
		add_cfg(RegNodata, 32'hffff8000);
		add_word(ReqFlush, 32'h0);
		add_word(ReqPush, 32'hffff8000);
		add_word(ReqPush, 32'h7fffffff);
		// A small raster with extreme samples, nodata zero and a stray push after
		// the last pixel but before the flushes drain it.
		add_cfg(RegRows, 3);
		add_cfg(RegCols, 3);
		add_cfg(RegRadius, 1);
		add_cfg(RegNodata, 32'h0);
		add_word(ReqPush, 32'h7fffffff);
		add_word(ReqPush, 32'h7fffffff);
		add_word(ReqPush, 32'h0);
		add_word(ReqFlush, 32'h0);
		add_word(ReqPush, 32'h80000000);
		add_word(ReqPush, 32'h80000000);
		add_word(ReqPush, 32'h7fffffff);
		add_word(ReqPush, 32'h0);
		add_word(ReqPush, 32'h0);
		add_word(ReqPush, 32'h0);
		add_word(ReqPush, 32'h12345678);
		for (int i = 0; i < 4; i++) add_word(ReqFlush, 32'h0);
		// Largest rows with oversized columns; left unfinished, then restarted.
		add_raster(65535, 8191, 0, 32'h80000000, 6, 1);
		// Largest radius with the largest nodata value.
		add_raster(2, 5, 7, 32'h7fffffff, 10, 12);
		add_raster(1, 1, 7, 32'h7fffffff, 1, 2);

		// Random rasters, mostly complete, now and then cut short.
		while (word_total < 410) begin
			rows = $urandom_range(1, 6);
			cols = $urandom_range(1, 8);
			rad = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
			case ($urandom_range(0, 3))
				0: nd = 32'hffff8000;
				1: nd = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
				default: nd = $urandom;
			endcase
			if ($urandom_range(0, 7) == 0) begin
				add_raster(rows, cols, rad, nd, $urandom_range(0, rows * cols), 1);
			end else begin
				add_raster(rows, cols, rad, nd, rows * cols,
				           ((rad < rows) ? rad : rows) * cols + 2);
			end
			if ($urandom_range(0, 4) == 0) add_drain();
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		wait (job_q.size() == 0 && !in_ch.valid && mean_q.size() == 0);
		repeat (Settle) @(posedge clk);
		if (errors == 0 && mean_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
